// ----- rtl/shp_pkg.sv -----
// Shared types and constants for the 3x3 sharpening filter.
// Used by every module in the rtl folder; depends on nothing.
package shp_pkg;

  // Sample and pixel geometry.
  localparam int DATA_W       = 8;
  localparam int CHANNELS     = 3;
  localparam int PIXEL_W      = DATA_W * CHANNELS;

  // Frame geometry limits.
  localparam int MAX_WIDTH    = 2048;
  localparam int HEIGHT_LIMIT = 2048;
  localparam int MIN_DIM      = 3;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
  localparam int DIM_W        = 12;
  localparam int TOTAL_W      = 2 * DIM_W;
  localparam int COUNT_W      = 22;
  localparam int CHCNT_W      = 2;

  // Configuration port.
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [DIM_W-1:0]   WIDTH_RESET    = 12'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RESET   = 12'd480;
  localparam logic [CHCNT_W-1:0] CHANNELS_RESET = 2'd3;

  // Item kinds carried on tuser.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Output queue.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef logic [CHANNELS-1:0][DATA_W-1:0] pixel_t;

  // One line store word: the pixel two rows up and the pixel one row up.
  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_pair_t;

  // One finished result.
  typedef struct packed {
    logic   frame_last;
    pixel_t samples;
  } result_t;

  // Request held between acceptance and the line store read.
  typedef struct packed {
    logic                is_pixel;
    logic                emit;
    logic                interior;
    logic                frame_last;
    logic [CHANNELS-1:0] chan_en;
    logic [COL_W-1:0]    col;
    pixel_t              px;
  } stage1_t;

  // Control that travels alongside the window into the kernel.
  typedef struct packed {
    logic                interior;
    logic [CHANNELS-1:0] chan_en;
  } kernel_ctl_t;

endpackage

// ----- rtl/shp_line_store.sv -----
// Two-row line store for the sharpening filter: one word holds both rows.
// Depends on shp_pkg for the word type and depth.
module shp_line_store (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [shp_pkg::COL_W-1:0]   rd_addr,
  output shp_pkg::line_pair_t         rd_data,
  input  logic                        wr_en,
  input  logic [shp_pkg::COL_W-1:0]   wr_addr,
  input  shp_pkg::line_pair_t         wr_data
);

  shp_pkg::line_pair_t mem [shp_pkg::MAX_WIDTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/shp_kernel.sv -----
// Laplacian sharpening arithmetic: 5*centre minus four neighbours, clamped.
// Depends on shp_pkg for pixel and control types.
module shp_kernel (
  input  shp_pkg::pixel_t     centre,
  input  shp_pkg::pixel_t     left,
  input  shp_pkg::pixel_t     right,
  input  shp_pkg::pixel_t     up,
  input  shp_pkg::pixel_t     down,
  input  shp_pkg::kernel_ctl_t ctl,
  output shp_pkg::pixel_t     result
);

  localparam int SUM_W = shp_pkg::DATA_W + 4;

  // Per-channel sum and clamp; border pixels and unused channels give zero.
  always_comb begin
    logic [SUM_W-1:0]        c5;
    logic [SUM_W-1:0]        nsum;
    logic signed [SUM_W-1:0] v;
    result = '0;
    for (int k = 0; k < shp_pkg::CHANNELS; k++) begin
      c5   = SUM_W'({centre[k], 2'b00}) + SUM_W'(centre[k]);
      nsum = SUM_W'(left[k]) + SUM_W'(right[k]) + SUM_W'(up[k]) + SUM_W'(down[k]);
      v    = $signed(c5 - nsum);
      if (ctl.interior && ctl.chan_en[k]) begin
        if (v[SUM_W-1]) begin
          result[k] = '0;
        end else if (v > $signed(SUM_W'(255))) begin
          result[k] = '1;
        end else begin
          result[k] = v[shp_pkg::DATA_W-1:0];
        end
      end
    end
  end

endmodule

// ----- rtl/shp_out_fifo.sv -----
// Small result queue that decouples the filter pipeline from the output side.
// Depends on shp_pkg for the result type and depth.
module shp_out_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  shp_pkg::result_t            wr_data,
  output logic                        rd_valid,
  input  logic                        rd_ready,
  output shp_pkg::result_t            rd_data,
  output logic [shp_pkg::FIFO_CW-1:0] count
);

  shp_pkg::result_t                 mem [shp_pkg::FIFO_DEPTH];
  logic [shp_pkg::FIFO_AW-1:0]      wr_ptr;
  logic [shp_pkg::FIFO_AW-1:0]      rd_ptr;
  logic                             rd_fire;

  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign rd_fire  = rd_valid && rd_ready;

  // Storage; the pipeline never writes when the queue is full.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_fire) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_fire) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/sharpen_3x3_filter.sv -----
// Throughput: one request per cycle while the result queue has room for all in flight;
// the line store port, read at acceptance and written back in the following cycle,
// and a four-entry result queue set that figure.
// Reset (rst, synchronous) clears counters, window, queue and registers to their
// defaults; the line stores are not cleared and hold undefined data until written.
// Depends on shp_pkg, shp_line_store, shp_kernel and shp_out_fifo.
module sharpen_3x3_filter (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port.
  input  logic                             cfg_wr_en,
  input  logic [shp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [shp_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [shp_pkg::PIXEL_W-1:0]      s_axis_tdata,  // in_sample0, in_sample1, in_sample2
  input  logic                             s_axis_tuser,  // op
  // Output stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [shp_pkg::PIXEL_W-1:0]      m_axis_tdata,  // out_sample0, out_sample1, out_sample2
  output logic                             m_axis_tlast   // frame_last
);

  // Configuration registers.
  logic [shp_pkg::DIM_W-1:0]   image_width;
  logic [shp_pkg::DIM_W-1:0]   image_height;
  logic [shp_pkg::CHCNT_W-1:0] channel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= shp_pkg::WIDTH_RESET;
      image_height  <= shp_pkg::HEIGHT_RESET;
      channel_count <= shp_pkg::CHANNELS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        shp_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        shp_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        shp_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[shp_pkg::CHCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size, clamped to the supported range.
  logic [shp_pkg::DIM_W-1:0]   eff_w;
  logic [shp_pkg::DIM_W-1:0]   eff_h;
  logic [shp_pkg::TOTAL_W-1:0] total_m1;

  always_comb begin
    eff_w = image_width;
    if (image_width < shp_pkg::DIM_W'(shp_pkg::MIN_DIM)) begin
      eff_w = shp_pkg::DIM_W'(shp_pkg::MIN_DIM);
    end else if (image_width > shp_pkg::DIM_W'(shp_pkg::MAX_WIDTH)) begin
      eff_w = shp_pkg::DIM_W'(shp_pkg::MAX_WIDTH);
    end
    eff_h = image_height;
    if (image_height < shp_pkg::DIM_W'(shp_pkg::MIN_DIM)) begin
      eff_h = shp_pkg::DIM_W'(shp_pkg::MIN_DIM);
    end else if (image_height > shp_pkg::DIM_W'(shp_pkg::HEIGHT_LIMIT)) begin
      eff_h = shp_pkg::DIM_W'(shp_pkg::HEIGHT_LIMIT);
    end
    total_m1 = (shp_pkg::TOTAL_W'(eff_w) * shp_pkg::TOTAL_W'(eff_h)) - 1'b1;
  end

  // Position and output counters.
  logic [shp_pkg::ROW_W-1:0]   in_row;
  logic [shp_pkg::COL_W-1:0]   in_col;
  logic [shp_pkg::COUNT_W-1:0] out_count;
  logic [shp_pkg::ROW_W-1:0]   in_row_next;
  logic [shp_pkg::COL_W-1:0]   in_col_next;
  logic [shp_pkg::COUNT_W-1:0] out_count_next;

  logic                        accept;
  logic                        is_flush;
  logic                        at_origin;
  logic                        emit;
  logic                        frame_end;
  logic [shp_pkg::COUNT_W-1:0] base_count;
  shp_pkg::stage1_t            s1_in;
  shp_pkg::stage1_t            s1;
  logic                        s1_valid;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_flush  = (s_axis_tuser == shp_pkg::OP_FLUSH);
  assign at_origin = (in_row == '0) && (in_col == '0);

  // Decide emission, frame end and the next position for the offered request.
  always_comb begin
    base_count = (!is_flush && at_origin) ? '0 : out_count;
    if (is_flush) begin
      emit = at_origin && (out_count != '0);
    end else begin
      emit = (in_row >= shp_pkg::ROW_W'(2)) ||
             ((in_row == shp_pkg::ROW_W'(1)) && (in_col != '0));
    end
    frame_end      = (shp_pkg::TOTAL_W'(base_count) >= total_m1);
    out_count_next = base_count;
    if (emit) begin
      out_count_next = frame_end ? '0 : base_count + 1'b1;
    end

    in_col_next = in_col;
    in_row_next = in_row;
    if (!is_flush) begin
      if ((shp_pkg::DIM_W'(in_col) + 1'b1) >= eff_w) begin
        in_col_next = '0;
        in_row_next = ((shp_pkg::DIM_W'(in_row) + 1'b1) >= eff_h) ? '0 : in_row + 1'b1;
      end else begin
        in_col_next = in_col + 1'b1;
      end
    end

    s1_in.is_pixel   = !is_flush;
    s1_in.emit       = emit;
    s1_in.interior   = !is_flush &&
                       (in_row >= shp_pkg::ROW_W'(2)) &&
                       (shp_pkg::DIM_W'(in_row) < eff_h) &&
                       (in_col >= shp_pkg::COL_W'(2)) &&
                       (shp_pkg::DIM_W'(in_col) < eff_w);
    s1_in.frame_last = frame_end;
    for (int k = 0; k < shp_pkg::CHANNELS; k++) begin
      s1_in.chan_en[k] = shp_pkg::CHCNT_W'(k) < channel_count;
    end
    s1_in.col = in_col;
    s1_in.px  = s_axis_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row    <= '0;
      in_col    <= '0;
      out_count <= '0;
    end else if (accept) begin
      in_row    <= in_row_next;
      in_col    <= in_col_next;
      out_count <= out_count_next;
    end
  end

  // First stage: request held while the line store read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (!is_flush || emit);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_in;
    end
  end

  // Line stores: read at acceptance, rotated and written back in the following cycle.
  shp_pkg::line_pair_t rd_pair;
  shp_pkg::line_pair_t wr_pair;
  logic                shift_en;

  assign shift_en       = s1_valid && s1.is_pixel;
  assign wr_pair.upper  = rd_pair.middle;
  assign wr_pair.middle = s1.px;

  shp_line_store u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_col),
    .rd_data (rd_pair),
    .wr_en   (shift_en),
    .wr_addr (s1.col),
    .wr_data (wr_pair)
  );

  // Second stage: the 3x3 window and the control of the result it yields.
  shp_pkg::pixel_t     win [3][3];
  logic                s2_valid;
  logic                s2_last;
  shp_pkg::kernel_ctl_t s2_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (shift_en) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= rd_pair.upper;
      win[1][2] <= rd_pair.middle;
      win[2][2] <= s1.px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_last          <= s1.frame_last;
      s2_ctl.interior  <= s1.interior;
      s2_ctl.chan_en   <= s1.chan_en;
    end
  end

  // Sharpening arithmetic on the window.
  shp_pkg::pixel_t  sharp;
  shp_pkg::result_t res;

  shp_kernel u_kernel (
    .centre (win[1][1]),
    .left   (win[1][0]),
    .right  (win[1][2]),
    .up     (win[0][1]),
    .down   (win[2][1]),
    .ctl    (s2_ctl),
    .result (sharp)
  );

  assign res.frame_last = s2_last;
  assign res.samples    = sharp;

  // Result queue; new requests are taken while it has room for all in flight.
  logic [shp_pkg::FIFO_CW-1:0] fifo_count;
  logic [shp_pkg::FIFO_CW-1:0] in_flight;
  shp_pkg::result_t            out_res;

  shp_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (s2_valid),
    .wr_data  (res),
    .rd_valid (m_axis_tvalid),
    .rd_ready (m_axis_tready),
    .rd_data  (out_res),
    .count    (fifo_count)
  );

  assign in_flight     = fifo_count + shp_pkg::FIFO_CW'(s1_valid) +
                         shp_pkg::FIFO_CW'(s2_valid);
  assign s_axis_tready = (in_flight < shp_pkg::FIFO_CW'(shp_pkg::FIFO_DEPTH));
  assign m_axis_tdata  = out_res.samples;
  assign m_axis_tlast  = out_res.frame_last;

endmodule

// ----- dv/sharpen_3x3_filter_checker.sv -----
// Scoreboard for the 3x3 sharpening filter: tracks configuration writes,
// predicts each result from the accepted requests and compares field by field.
// Depends on shp_pkg for widths, register indexes and request kinds.
module sharpen_3x3_filter_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [shp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [shp_pkg::PIXEL_W-1:0]    s_axis_tdata,   // in_sample0, in_sample1, in_sample2
  input  logic                           s_axis_tuser,   // op
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [shp_pkg::PIXEL_W-1:0]    m_axis_tdata,   // out_sample0, out_sample1, out_sample2
  input  logic                           m_axis_tlast,   // frame_last
  output int                             error_count,
  output int                             pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the register file.
  logic [shp_pkg::DIM_W-1:0]   width_reg;
  logic [shp_pkg::DIM_W-1:0]   height_reg;
  logic [shp_pkg::CHCNT_W-1:0] chan_reg;

  // Shadow copy of the filter state.
  shp_pkg::pixel_t upper_row [shp_pkg::MAX_WIDTH];
  shp_pkg::pixel_t middle_row [shp_pkg::MAX_WIDTH];
  shp_pkg::pixel_t win [3][3];
  int              row_pos;
  int              col_pos;
  int              frame_pos;

  // Sharpened pixels still owed by the block, oldest first.
  shp_pkg::result_t sharpened_q [$];

  // Width and height as the block uses them.
  function automatic int dim_limit(input logic [shp_pkg::DIM_W-1:0] v, input int lim);
    if (v < shp_pkg::MIN_DIM) return shp_pkg::MIN_DIM;
    if (v > lim) return lim;
    return int'(v);
  endfunction

  // 5*centre minus the four orthogonal neighbours, clamped to a byte.
  function automatic logic [shp_pkg::DATA_W-1:0] laplace_sample(input int k);
    int acc;
    acc = 5 * int'(win[1][1][k]) - int'(win[1][0][k]) - int'(win[1][2][k])
        - int'(win[0][1][k]) - int'(win[2][1][k]);
    if (acc < 0) acc = 0;
    else if (acc > 255) acc = 255;
    return acc[shp_pkg::DATA_W-1:0];
  endfunction

  // Builds one output pixel and advances the position within the output frame.
  function automatic shp_pkg::result_t emit_pixel(input bit interior);
    shp_pkg::result_t res;
    int               total;
    int               k;
    total = dim_limit(width_reg, shp_pkg::MAX_WIDTH) *
            dim_limit(height_reg, shp_pkg::HEIGHT_LIMIT);
    for (k = 0; k < shp_pkg::CHANNELS; k++) begin
      res.samples[k] = (interior && k < int'(chan_reg)) ? laplace_sample(k) : '0;
    end
    if (frame_pos >= total - 1) begin
      res.frame_last = 1'b1;
      frame_pos = 0;
    end else begin
      res.frame_last = 1'b0;
      frame_pos++;
    end
    return res;
  endfunction

  // Applies one request; returns 1 when it yields an output pixel.
  function automatic bit sharpen_step(input logic op, input shp_pkg::pixel_t px,
                                      output shp_pkg::result_t res);
    int w;
    int h;
    int col;
    int r;
    bit emits;
    bit interior;
    w = dim_limit(width_reg, shp_pkg::MAX_WIDTH);
    h = dim_limit(height_reg, shp_pkg::HEIGHT_LIMIT);

    // A flush only drains the tail of the previous frame.
    if (op == shp_pkg::OP_FLUSH) begin
      if (row_pos == 0 && col_pos == 0 && frame_pos != 0) begin
        res = emit_pixel(1'b0);
        return 1'b1;
      end
      return 1'b0;
    end

    // The first pixel of a frame drops whatever tail is left.
    if (row_pos == 0 && col_pos == 0) frame_pos = 0;

    col = col_pos % shp_pkg::MAX_WIDTH;
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = upper_row[col];
    win[1][2] = middle_row[col];
    win[2][2] = px;
    upper_row[col] = middle_row[col];
    middle_row[col] = px;

    emits = row_pos >= 2 || (row_pos == 1 && col_pos >= 1);
    interior = row_pos >= 2 && row_pos < h && col_pos >= 2 && col_pos < w;

    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end

    if (!emits) return 1'b0;
    res = emit_pixel(interior);
    return 1'b1;
  endfunction

  // Watch both streams and the register port at every rising edge.
  always @(posedge clk) begin : monitor
    shp_pkg::result_t predicted;
    shp_pkg::result_t want;
    shp_pkg::pixel_t  got;
    int               k;
    if (rst) begin
      width_reg  = shp_pkg::WIDTH_RESET;
      height_reg = shp_pkg::HEIGHT_RESET;
      chan_reg   = shp_pkg::CHANNELS_RESET;
      for (k = 0; k < shp_pkg::MAX_WIDTH; k++) begin
        upper_row[k]  = '0;
        middle_row[k] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      row_pos = 0;
      col_pos = 0;
      frame_pos = 0;
      sharpened_q.delete();
      error_count = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (sharpen_step(s_axis_tuser, s_axis_tdata, predicted))
          sharpened_q = {sharpened_q, predicted};
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (sharpened_q.size() == 0) begin
          $error("unexpected result: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
          error_count++;
        end else begin
          want = sharpened_q.pop_front();
          got = m_axis_tdata;
          for (k = 0; k < shp_pkg::CHANNELS; k++) begin
            if (got[k] !== want.samples[k]) begin
              $error("out_sample%0d: expected %0d, got %0d", k, want.samples[k], got[k]);
              error_count++;
            end
          end
          if (m_axis_tlast !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, m_axis_tlast);
            error_count++;
          end
        end
      end

      // New register values apply from the next request on.
      if (cfg_wr_en) begin
        case (cfg_index)
          shp_pkg::REG_IMAGE_WIDTH:   width_reg = cfg_data;
          shp_pkg::REG_IMAGE_HEIGHT:  height_reg = cfg_data;
          shp_pkg::REG_CHANNEL_COUNT: chan_reg = cfg_data[shp_pkg::CHCNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending_results = sharpened_q.size();
  end

endmodule

// ----- dv/sharpen_3x3_filter_tb.sv -----
// Top of the sharpening filter testbench: clock, reset, request stimulus,
// random back-pressure, watchdog and verdict.
// Depends on shp_pkg, sharpen_3x3_filter and sharpen_3x3_filter_checker.
module sharpen_3x3_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_PIXELS  = 45;

  logic                           clk;
  logic                           rst;
  logic                           cfg_wr_en;
  logic [shp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [shp_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [shp_pkg::PIXEL_W-1:0]    s_axis_tdata;   // in_sample0, in_sample1, in_sample2
  logic                           s_axis_tuser;   // op
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [shp_pkg::PIXEL_W-1:0]    m_axis_tdata;   // out_sample0, out_sample1, out_sample2
  logic                           m_axis_tlast;   // frame_last

  int error_count;
  int pending_results;

  int send_idle_pct;
  int recv_idle_pct;
  int cur_w;
  int cur_h;
  int stall_cycles;
  int request_total;
  int flush_total;
  int result_total;
  int frame_total;
  int setting_total;

  sharpen_3x3_filter u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  sharpen_3x3_filter_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .error_count     (error_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output back-pressure, redrawn at every falling edge.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Transfer counts and the stall watchdog.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        request_total++;
        if (s_axis_tuser == shp_pkg::OP_FLUSH) flush_total++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        result_total++;
        if (m_axis_tlast) frame_total++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 stall_cycles, pending_results);
        $display("FAIL sharpen_3x3_filter");
        $finish;
      end
    end
  end

  function automatic int dim_limit(input int v, input int lim);
    if (v < shp_pkg::MIN_DIM) return shp_pkg::MIN_DIM;
    if (v > lim) return lim;
    return v;
  endfunction

  // Pixel content: uniform, rail values only, or a flat mid-range patch.
  function automatic shp_pkg::pixel_t pick_pixel(input int style);
    shp_pkg::pixel_t px;
    int              k;
    for (k = 0; k < shp_pkg::CHANNELS; k++) begin
      case (style)
        1:       px[k] = $urandom_range(1) ? 8'hFF : 8'h00;
        2:       px[k] = 8'($urandom_range(100, 140));
        default: px[k] = 8'($urandom_range(255));
      endcase
    end
    return px;
  endfunction

  // Register value for a dimension: mostly in range, sometimes below the minimum.
  function automatic int pick_dim(input int hi);
    if ($urandom_range(7) == 0) return $urandom_range(0, shp_pkg::MIN_DIM - 1);
    return $urandom_range(shp_pkg::MIN_DIM, hi);
  endfunction

  // Entered and left at a falling edge; tvalid is written once per entry step.
  task automatic send_request(input logic op, input shp_pkg::pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Hold off new requests until every expected result is back and the
  // pipeline has settled behind any request that produced nothing.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [shp_pkg::CFG_IDX_W-1:0] idx, input int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[shp_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input int width_value, input int height_value,
                           input int chan_value);
    wait_idle();
    write_reg(shp_pkg::REG_IMAGE_WIDTH, width_value);
    write_reg(shp_pkg::REG_IMAGE_HEIGHT, height_value);
    write_reg(shp_pkg::REG_CHANNEL_COUNT, chan_value);
    cur_w = dim_limit(width_value, shp_pkg::MAX_WIDTH);
    cur_h = dim_limit(height_value, shp_pkg::HEIGHT_LIMIT);
    setting_total++;
  endtask

  // One full frame with stray flushes inside it, then a tail of flushes that
  // may drain it completely, partly, not at all, or overshoot.
  task automatic send_frame(input bit swap_channels);
    int style;
    int total;
    int tail;
    int p;
    style = $urandom_range(2);
    total = cur_w * cur_h;
    for (p = 0; p < total; p++) begin
      // Channel count changes mid-frame while the counters keep running.
      if (swap_channels && p == total / 2) begin
        wait_idle();
        write_reg(shp_pkg::REG_CHANNEL_COUNT, $urandom_range(3));
      end
      if (p != 0 && $urandom_range(99) < 3) send_request(shp_pkg::OP_FLUSH, pick_pixel(0));
      send_request(shp_pkg::OP_PIXEL, pick_pixel(style));
    end
    case ($urandom_range(3))
      0:       tail = 0;
      1:       tail = $urandom_range(1, cur_w);
      2:       tail = cur_w + 1;
      default: tail = cur_w + 1 + $urandom_range(1, 3);
    endcase
    repeat (tail) send_request(shp_pkg::OP_FLUSH, pick_pixel(0));
  endtask

  // Two 3x3 frames: one pushing both clamps, one with an exact in-range sum.
  task automatic send_directed();
    shp_pkg::pixel_t clamp_grid [9];
    shp_pkg::pixel_t exact_grid [9];
    int              i;
    for (i = 0; i < 9; i++) begin
      clamp_grid[i] = pick_pixel(0);
      exact_grid[i] = pick_pixel(0);
    end
    // Channel 0 saturates high, channel 1 saturates low, channel 2 is flat.
    clamp_grid[4] = {8'd100, 8'd0, 8'd255};
    clamp_grid[1] = {8'd100, 8'd255, 8'd0};
    clamp_grid[3] = {8'd100, 8'd255, 8'd0};
    clamp_grid[5] = {8'd100, 8'd255, 8'd0};
    clamp_grid[7] = {8'd100, 8'd255, 8'd0};
    // 5*60 - (10+20+30+40) = 200 on every channel.
    exact_grid[4] = {3{8'd60}};
    exact_grid[1] = {3{8'd10}};
    exact_grid[3] = {3{8'd20}};
    exact_grid[5] = {3{8'd30}};
    exact_grid[7] = {3{8'd40}};
    for (i = 0; i < 9; i++) send_request(shp_pkg::OP_PIXEL, clamp_grid[i]);
    // Four flushes drain the tail, the fifth finds nothing to drain.
    repeat (5) send_request(shp_pkg::OP_FLUSH, pick_pixel(0));
    // No flush after this frame, so the next pixel drops its tail.
    for (i = 0; i < 9; i++) send_request(shp_pkg::OP_PIXEL, exact_grid[i]);
  endtask

  // Stimulus and verdict.
  initial begin
    int mode;
    int pixels;
    int frame_idx;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = shp_pkg::REG_IMAGE_WIDTH;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = shp_pkg::OP_PIXEL;
    send_idle_pct = 23;
    recv_idle_pct = 88;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    configure(3, 3, 3);
    send_directed();

    // Random frames under each idling pattern.
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (4) begin
        configure(pick_dim(12), pick_dim(8), $urandom_range(3));
        pixels = 0;
        frame_idx = 0;
        while (pixels < PHASE_PIXELS) begin
          send_frame(frame_idx == 1);
          pixels += cur_w * cur_h;
          frame_idx++;
        end
      end
    end

    // One wide, short frame and one narrow, tall frame.
    configure(31, shp_pkg::MIN_DIM, 3);
    send_frame(1'b0);
    configure(1, 30, 2);
    send_frame(1'b0);

    wait_idle();
    $display("Sent %0d requests (%0d flushes) over %0d register settings.",
             request_total, flush_total, setting_total);
    $display("Checked %0d results, %0d of them closing a frame.", result_total, frame_total);
    if (error_count == 0 && pending_results == 0) begin
      $display("PASS sharpen_3x3_filter");
    end else begin
      $display("FAIL sharpen_3x3_filter");
    end
    $finish;
  end

endmodule
